// ===== rtl/core/twpa_pkg.sv =====
// Shared types and constants for the temporal weighted pixel average block.
package twpa_pkg;

   // Reference set size and field widths
   localparam int MAX_REFS   = 6;
   localparam int PIXEL_W    = 8;
   localparam int WEIGHT_W   = 9;
   localparam int REF_CNT_W  = 3;
   localparam int PROD_W     = PIXEL_W + WEIGHT_W;
   localparam int PAIR_W     = PROD_W + 1;
   localparam int SUM_W      = 21;
   localparam int FULL_W     = 20;
   localparam int RESULT_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = MAX_REFS * WEIGHT_W;

   typedef logic [PIXEL_W-1:0]    pixel_type;
   typedef logic [WEIGHT_W-1:0]   weight_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [PAIR_W-1:0]     pair_type;
   typedef logic [SUM_W-1:0]      sum_type;
   typedef logic [REF_CNT_W-1:0]  ref_cnt_type;

   // Output format select
   typedef enum logic [1:0] {
      OUT_MODE_ROUND8 = 2'd0,
      OUT_MODE_SPLIT  = 2'd1,
      OUT_MODE_SAT16  = 2'd2,
      OUT_MODE_RAW    = 2'd3
   } out_mode_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WEIGHT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_WEIGHTS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BWD_WEIGHTS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_REFS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MODE    = 3'd4;

   // Reset values
   localparam weight_type  SRC_WEIGHT_RST = 9'd256;
   localparam ref_cnt_type NUM_REFS_RST   = 3'd1;

   // Rounding and saturation limits
   localparam logic [RESULT_W:0]   ROUND_BIAS = 17'd128;
   localparam logic [PIXEL_W:0]    BYTE_MAX   = 9'd255;
   localparam sum_type             SAT16_MAX  = 21'd65535;
   localparam sum_type             FULL_MAX   = 21'd1048575;

endpackage

// ===== rtl/core/temporal_weighted_pixel_average_top.sv =====
// Top level of the temporal weighted pixel average block.
//
// Usage:
//   Requests enter on the req_ channel (valid/ready): one source pixel and six
//   forward and six backward reference pixels packed as bytes. Each request
//   gives exactly one response on the rsp_ channel (valid/ready).
//   Weights, reference count and output format are written through the csr_
//   channel, which is always ready; write it only while no request is in flight.
// Pipeline and throughput:
//   An accepted request passes the input register, the product register
//   (thirteen 8x9 multipliers) and the result register (seven-term adder and
//   output formatting) before its response is valid. One request is accepted
//   every cycle while the response side keeps up.
// Reset:
//   Synchronous reset empties the pipeline and restores src_weight 256, zero
//   reference weights, num_refs 1 and the rounded 8-bit output format.
// Stall:
//   While a response waits and rsp_ready is low, the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated.
module temporal_weighted_pixel_average_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [twpa_pkg::PIXEL_W-1:0]        req_src_pixel,
   input  logic [twpa_pkg::MAX_REFS*twpa_pkg::PIXEL_W-1:0] req_fwd_pixels,
   input  logic [twpa_pkg::MAX_REFS*twpa_pkg::PIXEL_W-1:0] req_bwd_pixels,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [twpa_pkg::RESULT_W-1:0]       rsp_result_value,
   output logic [twpa_pkg::PIXEL_W-1:0]        rsp_low_byte,
   output logic [twpa_pkg::FULL_W-1:0]         rsp_full_sum,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [twpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [twpa_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int PX_BUS_W = twpa_pkg::MAX_REFS * twpa_pkg::PIXEL_W;

   // Configuration registers
   twpa_pkg::weight_type                 src_weight_ff;
   logic [twpa_pkg::CSR_DATA_W-1:0]      fwd_weights_ff;
   logic [twpa_pkg::CSR_DATA_W-1:0]      bwd_weights_ff;
   twpa_pkg::ref_cnt_type                num_refs_ff;
   twpa_pkg::out_mode_type               out_mode_ff;

   // Pipeline registers
   logic                                 in_valid_ff;
   twpa_pkg::pixel_type                  in_src_ff;
   logic [PX_BUS_W-1:0]                  in_fwd_ff;
   logic [PX_BUS_W-1:0]                  in_bwd_ff;

   logic                                 prod_valid_ff;
   twpa_pkg::prod_type                   src_prod_ff;
   twpa_pkg::prod_type                   src_prod_in;
   twpa_pkg::pair_type                   pair_ff [twpa_pkg::MAX_REFS];
   twpa_pkg::pair_type                   pair_in [twpa_pkg::MAX_REFS];

   logic                                 rsp_valid_ff;
   logic [twpa_pkg::RESULT_W-1:0]        result_ff;
   logic [twpa_pkg::RESULT_W-1:0]        result_in;
   twpa_pkg::pixel_type                  low_ff;
   twpa_pkg::pixel_type                  low_in;
   logic [twpa_pkg::FULL_W-1:0]          full_ff;
   logic [twpa_pkg::FULL_W-1:0]          full_in;

   logic                                 advance;
   twpa_pkg::ref_cnt_type                n_eff;
   twpa_pkg::sum_type                    sum;
   twpa_pkg::sum_type                    sat16;
   logic [twpa_pkg::RESULT_W:0]          rounded;

   // Move the whole pipeline unless a response is held
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // Write configuration registers, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_weight_ff  <= twpa_pkg::SRC_WEIGHT_RST;
         fwd_weights_ff <= '0;
         bwd_weights_ff <= '0;
         num_refs_ff    <= twpa_pkg::NUM_REFS_RST;
         out_mode_ff    <= twpa_pkg::OUT_MODE_ROUND8;
      end else if (csr_valid) begin
         case (csr_index)
            twpa_pkg::CSR_SRC_WEIGHT:  src_weight_ff  <= csr_data[twpa_pkg::WEIGHT_W-1:0];
            twpa_pkg::CSR_FWD_WEIGHTS: fwd_weights_ff <= csr_data;
            twpa_pkg::CSR_BWD_WEIGHTS: bwd_weights_ff <= csr_data;
            twpa_pkg::CSR_NUM_REFS:    num_refs_ff    <= csr_data[twpa_pkg::REF_CNT_W-1:0];
            twpa_pkg::CSR_OUT_MODE:
               out_mode_ff <= twpa_pkg::out_mode_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   // Clamp the reference count to 1..MAX_REFS
   always_comb begin
      n_eff = num_refs_ff;
      if (num_refs_ff == '0) begin
         n_eff = twpa_pkg::ref_cnt_type'(1);
      end else if (num_refs_ff > twpa_pkg::ref_cnt_type'(twpa_pkg::MAX_REFS)) begin
         n_eff = twpa_pkg::ref_cnt_type'(twpa_pkg::MAX_REFS);
      end
   end

   // Form source product and per-reference pair sums, zero unused pairs
   always_comb begin
      twpa_pkg::prod_type fp;
      twpa_pkg::prod_type bp;
      src_prod_in = twpa_pkg::prod_type'(in_src_ff) * twpa_pkg::prod_type'(src_weight_ff);
      for (int i = 0; i < twpa_pkg::MAX_REFS; i++) begin
         fp = twpa_pkg::prod_type'(in_fwd_ff[i*twpa_pkg::PIXEL_W +: twpa_pkg::PIXEL_W])
              * twpa_pkg::prod_type'(fwd_weights_ff[i*twpa_pkg::WEIGHT_W +: twpa_pkg::WEIGHT_W]);
         bp = twpa_pkg::prod_type'(in_bwd_ff[i*twpa_pkg::PIXEL_W +: twpa_pkg::PIXEL_W])
              * twpa_pkg::prod_type'(bwd_weights_ff[i*twpa_pkg::WEIGHT_W +: twpa_pkg::WEIGHT_W]);
         if (twpa_pkg::ref_cnt_type'(i) < n_eff) begin
            pair_in[i] = twpa_pkg::pair_type'(fp) + twpa_pkg::pair_type'(bp);
         end else begin
            pair_in[i] = '0;
         end
      end
   end

   // Add the terms and format the response
   always_comb begin
      sum = twpa_pkg::sum_type'(src_prod_ff);
      for (int i = 0; i < twpa_pkg::MAX_REFS; i++) begin
         sum = sum + twpa_pkg::sum_type'(pair_ff[i]);
      end
      sat16   = (sum > twpa_pkg::SAT16_MAX) ? twpa_pkg::SAT16_MAX : sum;
      rounded = sat16[twpa_pkg::RESULT_W:0] + twpa_pkg::ROUND_BIAS;
      full_in = (sum > twpa_pkg::FULL_MAX) ? twpa_pkg::FULL_MAX[twpa_pkg::FULL_W-1:0]
                                           : sum[twpa_pkg::FULL_W-1:0];
      low_in  = '0;
      unique case (out_mode_ff)
         twpa_pkg::OUT_MODE_ROUND8: begin
            if (rounded[twpa_pkg::RESULT_W:8] > twpa_pkg::BYTE_MAX) begin
               result_in = twpa_pkg::RESULT_W'(twpa_pkg::BYTE_MAX);
            end else begin
               result_in = twpa_pkg::RESULT_W'(rounded[twpa_pkg::RESULT_W:8]);
            end
         end
         twpa_pkg::OUT_MODE_SPLIT: begin
            result_in = twpa_pkg::RESULT_W'(sat16[twpa_pkg::RESULT_W-1:8]);
            low_in    = sat16[7:0];
         end
         twpa_pkg::OUT_MODE_SAT16: result_in = sat16[twpa_pkg::RESULT_W-1:0];
         twpa_pkg::OUT_MODE_RAW:   result_in = '0;
      endcase
   end

   // Advance pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         in_valid_ff   <= req_valid;
         prod_valid_ff <= in_valid_ff;
         rsp_valid_ff  <= prod_valid_ff;
      end
   end

   // Advance pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         in_src_ff   <= req_src_pixel;
         in_fwd_ff   <= req_fwd_pixels;
         in_bwd_ff   <= req_bwd_pixels;
         src_prod_ff <= src_prod_in;
         pair_ff     <= pair_in;
         result_ff   <= result_in;
         low_ff      <= low_in;
         full_ff     <= full_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = result_ff;
   assign rsp_low_byte     = low_ff;
   assign rsp_full_sum     = full_ff;

endmodule

// ===== dv/twpa_blend_checker.sv =====
// Response checker for the temporal weighted pixel average block: mirrors, predicts, compares.
module twpa_blend_checker
   import twpa_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [PIXEL_W-1:0]            req_src_pixel,
   input  logic [MAX_REFS*PIXEL_W-1:0]   req_fwd_pixels,
   input  logic [MAX_REFS*PIXEL_W-1:0]   req_bwd_pixels,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [RESULT_W-1:0]           rsp_result_value,
   input  logic [PIXEL_W-1:0]            rsp_low_byte,
   input  logic [FULL_W-1:0]             rsp_full_sum,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   output int                            error_count,
   output int                            outstanding,
   output int                            responses_checked
);

   typedef struct packed {
      logic [RESULT_W-1:0] value;
      pixel_type           low;
      logic [FULL_W-1:0]   full;
   } blend_result_type;

   // Mirror of the block's registers
   weight_type                  shadow_src_weight = SRC_WEIGHT_RST;
   logic [CSR_DATA_W-1:0]       shadow_fwd_weights = '0;
   logic [CSR_DATA_W-1:0]       shadow_bwd_weights = '0;
   ref_cnt_type                 shadow_num_refs = NUM_REFS_RST;
   out_mode_type                shadow_out_mode = OUT_MODE_ROUND8;

   blend_result_type expected_blends[$];
   int failures = 0;
   int pending_count = 0;
   int checked_count = 0;

   assign error_count       = failures;
   assign outstanding       = pending_count;
   assign responses_checked = checked_count;

   // Weighted temporal average of one request under the current register settings
   function automatic blend_result_type blend_pixels(
      input pixel_type                     src,
      input logic [MAX_REFS*PIXEL_W-1:0]   fwd,
      input logic [MAX_REFS*PIXEL_W-1:0]   bwd
   );
      int unsigned      pairs;
      logic [SUM_W-1:0] total;
      logic [15:0]      sat16;
      logic [16:0]      biased;
      logic [8:0]       rounded;
      blend_result_type r;
      // clamp the pair count to 1..MAX_REFS
      pairs = shadow_num_refs;
      if (pairs < 1) pairs = 1;
      if (pairs > MAX_REFS) pairs = MAX_REFS;
      total = src * shadow_src_weight;
      for (int i = 0; i < MAX_REFS; i++) begin
         if (i < pairs) begin
            total += fwd[PIXEL_W*i +: PIXEL_W] * shadow_fwd_weights[WEIGHT_W*i +: WEIGHT_W];
            total += bwd[PIXEL_W*i +: PIXEL_W] * shadow_bwd_weights[WEIGHT_W*i +: WEIGHT_W];
         end
      end
      sat16 = (total > 21'd65535) ? 16'hFFFF : total[15:0];
      r = '0;
      r.full = (total > 21'd1048575) ? 20'hFFFFF : total[FULL_W-1:0];
      case (shadow_out_mode)
         OUT_MODE_ROUND8: begin
            // round wide so a sum near full scale cannot wrap
            biased  = {1'b0, sat16} + 17'd128;
            rounded = biased[16:8];
            r.value = (rounded > 9'd255) ? 16'd255 : {7'd0, rounded};
         end
         OUT_MODE_SPLIT: begin
            r.value = {8'd0, sat16[15:8]};
            r.low   = sat16[7:0];
         end
         OUT_MODE_SAT16: r.value = sat16;
         default:        r.value = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      blend_result_type predicted;
      if (reset) begin
         // drop everything and restore reset values
         shadow_src_weight  = SRC_WEIGHT_RST;
         shadow_fwd_weights = '0;
         shadow_bwd_weights = '0;
         shadow_num_refs    = NUM_REFS_RST;
         shadow_out_mode    = OUT_MODE_ROUND8;
         expected_blends.delete();
      end else begin
         // compare each accepted response with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_blends.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("checker: response %h/%h/%h with no request outstanding",
                           rsp_result_value, rsp_low_byte, rsp_full_sum);
            end else begin
               predicted = expected_blends.pop_front();
               checked_count++;
               if (rsp_result_value !== predicted.value || rsp_low_byte !== predicted.low ||
                   rsp_full_sum !== predicted.full) begin
                  failures++;
                  if (failures <= 10)
                     $display("checker: mismatch value exp %0d got %0d, low exp %0d got %0d,",
                              predicted.value, rsp_result_value, predicted.low, rsp_low_byte,
                              " full exp %0d got %0d", predicted.full, rsp_full_sum);
               end
            end
         end
         // predict each accepted request
         if (req_valid && req_ready)
            expected_blends.push_back(blend_pixels(req_src_pixel, req_fwd_pixels,
                                                   req_bwd_pixels));
         // track register writes; unknown indexes are ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SRC_WEIGHT:  shadow_src_weight  = csr_data[WEIGHT_W-1:0];
               CSR_FWD_WEIGHTS: shadow_fwd_weights = csr_data;
               CSR_BWD_WEIGHTS: shadow_bwd_weights = csr_data;
               CSR_NUM_REFS:    shadow_num_refs    = csr_data[REF_CNT_W-1:0];
               CSR_OUT_MODE:    shadow_out_mode    = out_mode_type'(csr_data[1:0]);
               default: ;
            endcase
         end
      end
      pending_count = expected_blends.size();
   end

endmodule

// ===== dv/temporal_weighted_pixel_average_top_tb.sv =====
// Testbench top for the temporal weighted pixel average block: stimulus, register setup, verdict.
module temporal_weighted_pixel_average_top_tb;
   import twpa_pkg::*;

   localparam int PIPE_LATENCY    = 3;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd5;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   pixel_type                     req_src_pixel = '0;
   logic [MAX_REFS*PIXEL_W-1:0]   req_fwd_pixels = '0;
   logic [MAX_REFS*PIXEL_W-1:0]   req_bwd_pixels = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [RESULT_W-1:0]           rsp_result_value;
   logic [PIXEL_W-1:0]            rsp_low_byte;
   logic [FULL_W-1:0]             rsp_full_sum;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_data = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int requests_sent  = 0;
   int register_writes = 0;
   int error_count;
   int outstanding;
   int responses_checked;

   temporal_weighted_pixel_average_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_pixel    (req_src_pixel),
      .req_fwd_pixels   (req_fwd_pixels),
      .req_bwd_pixels   (req_bwd_pixels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_low_byte     (rsp_low_byte),
      .rsp_full_sum     (rsp_full_sum),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   twpa_blend_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_src_pixel     (req_src_pixel),
      .req_fwd_pixels    (req_fwd_pixels),
      .req_bwd_pixels    (req_bwd_pixels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_value  (rsp_result_value),
      .rsp_low_byte      (rsp_low_byte),
      .rsp_full_sum      (rsp_full_sum),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .error_count       (error_count),
      .outstanding       (outstanding),
      .responses_checked (responses_checked)
   );

   always #6 clock = ~clock;

   // Randomly stall the response side
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Pixel biased toward black and white
   function automatic pixel_type random_pixel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return pixel_type'($urandom);
      endcase
   endfunction

   function automatic logic [MAX_REFS*PIXEL_W-1:0] random_ref_pixels();
      logic [MAX_REFS*PIXEL_W-1:0] px;
      for (int i = 0; i < MAX_REFS; i++) px[PIXEL_W*i +: PIXEL_W] = random_pixel();
      return px;
   endfunction

   // Weight up to a cap, with the ends of the range favored
   function automatic weight_type random_weight(input int cap);
      case ($urandom_range(7))
         0:       return '0;
         1:       return weight_type'(cap);
         default: return weight_type'($urandom_range(cap));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_weights(input int cap);
      logic [CSR_DATA_W-1:0] w;
      for (int i = 0; i < MAX_REFS; i++) w[WEIGHT_W*i +: WEIGHT_W] = random_weight(cap);
      return w;
   endfunction

   // Present one request after a random gap, hold until accepted
   task automatic send_request(input pixel_type src, input logic [MAX_REFS*PIXEL_W-1:0] fwd,
                               input logic [MAX_REFS*PIXEL_W-1:0] bwd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_src_pixel  <= src;
      req_fwd_pixels <= fwd;
      req_bwd_pixels <= bwd;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Hold valid high across back-to-back writes; caller drops it
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      register_writes++;
   endtask

   // Pause requests until every response is back and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic configure(input weight_type src_w, input logic [CSR_DATA_W-1:0] fwd_w,
                            input logic [CSR_DATA_W-1:0] bwd_w, input ref_cnt_type refs,
                            input out_mode_type mode);
      drain();
      write_register(CSR_SRC_WEIGHT, CSR_DATA_W'(src_w));
      write_register(CSR_FWD_WEIGHTS, fwd_w);
      write_register(CSR_BWD_WEIGHTS, bwd_w);
      write_register(CSR_NUM_REFS, CSR_DATA_W'(refs));
      write_register(CSR_OUT_MODE, CSR_DATA_W'(mode));
      // an index past the register list must leave everything untouched
      write_register(CSR_FIRST_UNUSED + CSR_IDX_W'($urandom_range(2)),
                     CSR_DATA_W'({$urandom, $urandom}));
      csr_valid <= 1'b0;
   endtask

   initial begin
      int           cap;
      ref_cnt_type  refs;
      out_mode_type mode;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset values: src weight 256, one pair with zero weights, rounded output
      send_request(8'd0, '1, '1);
      send_request(8'd255, '0, '0);
      send_request(8'd128, 48'h0102_0304_0506, 48'hFFEE_DDCC_BBAA);

      // Rounding must not wrap when the sum is at or past full scale
      configure(9'd257, '0, '0, 3'd1, OUT_MODE_ROUND8);
      send_request(8'd255, '0, '0);
      send_request(8'd254, '0, '0);
      send_request(8'd1, '1, '1);
      configure(9'd511, {MAX_REFS{9'd256}}, {MAX_REFS{9'd1}}, 3'd2, OUT_MODE_ROUND8);
      send_request(8'd255, '1, '1);
      send_request(8'd0, 48'h0000_0000_0080, '0);

      // All weights at 511: full sum saturates
      configure(9'h1FF, '1, '1, 3'd6, OUT_MODE_SAT16);
      send_request(8'd255, '1, '1);
      send_request(8'd0, '0, '0);
      send_request(8'd170, 48'hAA55_AA55_AA55, 48'h55AA_55AA_55AA);

      // Reference count above the limit acts as the limit
      configure(9'd0, '1, '1, 3'd7, OUT_MODE_RAW);
      send_request(8'd255, '1, '1);
      send_request(random_pixel(), random_ref_pixels(), random_ref_pixels());

      // Reference count of zero acts as one
      configure(9'd256, {MAX_REFS{9'd37}}, {MAX_REFS{9'd200}}, 3'd0, OUT_MODE_SPLIT);
      send_request(8'd255, '1, '1);
      send_request(8'd17, 48'h0000_0000_00FF, 48'hFF00_0000_0001);
      send_request(random_pixel(), random_ref_pixels(), random_ref_pixels());

      // Nominal denoiser weights, split output
      configure(9'd128, {MAX_REFS{9'd0}} | 54'd32, 54'd32 << 9, 3'd3, OUT_MODE_SPLIT);
      send_request(8'd255, '1, '1);
      send_request(8'd100, 48'h0000_00C8_3200, 48'h0000_0000_0A00);

      // Random phases: register setting and idle pattern change together
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 3)
            0:       cap = 511;
            1:       cap = 256;
            default: cap = 40;
         endcase
         refs = ref_cnt_type'($urandom);
         mode = out_mode_type'(2'((phase + phase / 4) % 4));
         configure(random_weight(cap), random_weights(cap), random_weights(cap), refs, mode);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         repeat (ITEMS_PER_PHASE)
            send_request(random_pixel(), random_ref_pixels(), random_ref_pixels());
      end

      drain();
      $display("run covered %0d requests, %0d register writes, all four output formats",
               requests_sent, register_writes);
      $display("%0d responses compared, %0d failures", responses_checked, error_count);
      if (error_count == 0 && outstanding == 0)
         $display("temporal_weighted_pixel_average_top_tb: clean");
      else
         $display("temporal_weighted_pixel_average_top_tb: errors");
      $finish;
   end

   // Watchdog
   initial begin
      #(12 * 400000);
      $display("timeout with %0d responses outstanding", outstanding);
      $display("temporal_weighted_pixel_average_top_tb: errors");
      $finish;
   end

endmodule
